/* sv/bsp_pkg.sv */
// Shared types, codes and helpers for the bouncing-sphere physics step.
// Used by the controller, the datapath, the root/divide unit, the top level
// and the port checker. Depends on nothing.
`default_nettype none

package bsp_pkg;

  // Default number of table slots.
  localparam int BSP_MAX_SPHERES = 8;

  // Iteration counts of the shared root/divide unit.
  localparam int ROOT_STEPS = 25;
  localparam int DIV_STEPS  = 17;

  typedef logic signed [23:0] q24_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ACTIVE_COUNT = 3'd0,
    CFG_BOX_MIN_X    = 3'd1,
    CFG_BOX_MIN_Y    = 3'd2,
    CFG_BOX_MIN_Z    = 3'd3,
    CFG_BOX_MAX_X    = 3'd4,
    CFG_BOX_MAX_Y    = 3'd5,
    CFG_BOX_MAX_Z    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic        mode;
    logic [2:0]  sphere_index;
    q24_t        center_x;
    q24_t        center_y;
    q24_t        center_z;
    q24_t        velocity_x;
    q24_t        velocity_y;
    q24_t        velocity_z;
    logic [15:0] radius;
  } in_item_t;

  typedef struct packed {
    logic [2:0] result_index;
    q24_t       moved_x;
    q24_t       moved_y;
    q24_t       moved_z;
    q24_t       speed_x;
    q24_t       speed_y;
    q24_t       speed_z;
    logic       last_sphere;
  } out_item_t;

  // One table entry; component 0 is x.
  typedef struct packed {
    logic [2:0][23:0] pos;
    logic [2:0][23:0] vel;
    logic [15:0]      radius;
  } sphere_t;

  // Datapath operations.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_READ,
    OP_TAKE_I,
    OP_TAKE_J,
    OP_MOVE,
    OP_DIFF,
    OP_MUL,
    OP_ACC_ADD,
    OP_ACC_SUB,
    OP_ACC_ADD_HI,
    OP_ACC_CLR,
    OP_SQRT_GO,
    OP_TAKE_ROOT,
    OP_DIV_GO,
    OP_TAKE_Q,
    OP_SAVE_DELTA,
    OP_APPLY,
    OP_WB_I,
    OP_WB_J,
    OP_EMIT
  } dp_op_t;

  // Multiplier operand selection.
  typedef enum logic [2:0] {
    MS_DD,
    MS_RR,
    MS_UVI,
    MS_UVJ,
    MS_UDL,
    MS_UDH
  } mul_sel_t;

  typedef struct packed {
    dp_op_t     op;
    mul_sel_t   msel;
    logic [1:0] k;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic overlap;
    logic a_pos;
    logic unit_busy;
  } dp_status_t;

  function automatic logic [23:0] sat24(input logic signed [25:0] v);
    if (v > 26'sd8388607) begin
      return 24'h7FFFFF;
    end else if (v < -26'sd8388608) begin
      return 24'h800000;
    end else begin
      return v[23:0];
    end
  endfunction

  function automatic logic [23:0] abs_sat24(input logic [23:0] v);
    if (v == 24'h800000) begin
      return 24'h7FFFFF;
    end else if (v[23]) begin
      return ~v + 24'd1;
    end else begin
      return v;
    end
  endfunction

endpackage

`default_nettype wire

/* sv/bouncing_sphere_physics_step.sv */
// Top level of the bouncing-sphere physics step: configuration registers,
// sequencer and datapath. Depends on bsp_pkg, bsp_ctrl and bsp_dpath.
`default_nettype none

// A load item (mode 0) writes one table slot and gives no beat on the
// result side; busy stays low. A tick item (mode 1) moves and bounces
// each active sphere and then tests it against every later sphere, and
// afterwards reports every active sphere in index order, with last_sphere
// set on the final beat. Result beats are shown for one cycle on out_valid
// and cannot be held off, so the receiver must take every beat as it
// comes. The overlapping pairs dominate the cost of a tick: it is set by
// the shared iterative root/divide unit (the square root and each of the
// three direction components) and by the single 25x25 multiplier that
// forms every square, dot product and velocity correction in turn. Busy
// stays high from the cycle after a tick is taken and falls in the cycle
// in which the last beat is on the result ports. Configuration must only
// be written while busy is low.
module bouncing_sphere_physics_step import bsp_pkg::*; #(
  parameter int MAX_SPHERES = BSP_MAX_SPHERES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire in_item_t    in_data,
  output logic             busy,
  output logic             out_valid,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata
);

  localparam int IW = $clog2(MAX_SPHERES);

  logic [3:0] active_count_r;
  q24_t       box_min_r [3];
  q24_t       box_max_r [3];

  logic          in_accept;
  dp_cmd_t       cmd;
  dp_status_t    status;
  logic [IW-1:0] addr;

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_count_r <= 4'd8;
      box_min_r[0]   <= -24'sd98304;
      box_min_r[1]   <= -24'sd98304;
      box_min_r[2]   <= -24'sd65536;
      box_max_r[0]   <= 24'sd98304;
      box_max_r[1]   <= 24'sd98304;
      box_max_r[2]   <= 24'sd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE_COUNT: active_count_r <= cfg_wdata[3:0];
        CFG_BOX_MIN_X:    box_min_r[0]   <= cfg_wdata;
        CFG_BOX_MIN_Y:    box_min_r[1]   <= cfg_wdata;
        CFG_BOX_MIN_Z:    box_min_r[2]   <= cfg_wdata;
        CFG_BOX_MAX_X:    box_max_r[0]   <= cfg_wdata;
        CFG_BOX_MAX_Y:    box_max_r[1]   <= cfg_wdata;
        CFG_BOX_MAX_Z:    box_max_r[2]   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // A beat is taken whenever start is high while the block is idle.
  assign in_accept = start && !busy;

  bsp_ctrl #(.MAX_SPHERES(MAX_SPHERES)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .tick_req     (in_data.mode),
    .active_count (active_count_r),
    .status       (status),
    .busy         (busy),
    .cmd          (cmd),
    .addr         (addr)
  );

  bsp_dpath #(.MAX_SPHERES(MAX_SPHERES)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_we   (in_accept && !in_data.mode),
    .in_data   (in_data),
    .cmd       (cmd),
    .addr      (addr),
    .box_min   (box_min_r),
    .box_max   (box_max_r),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* sv/bsp_rootdiv.sv */
// Shared iterative unit: integer square root (two radicand bits a cycle)
// and unsigned division giving one quotient bit a cycle.
// Depends on bsp_pkg for the step counts.
`default_nettype none

module bsp_rootdiv import bsp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        div_mode,
  input  wire logic [49:0] rad,
  input  wire logic [24:0] num,
  input  wire logic [24:0] den,
  output logic             busy,
  output logic [24:0]      res
);

  logic        busy_r, busy_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        mode_r;
  logic [49:0] x_r;
  logic [27:0] rem_r;
  logic [24:0] res_r;
  logic [24:0] den_r;

  logic [27:0] r4, trial, r2, den28;

  always_comb begin
    r4    = {rem_r[25:0], x_r[49:48]};
    trial = {1'b0, res_r, 2'b01};
    r2    = {rem_r[26:0], x_r[49]};
    den28 = {3'b000, den_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = div_mode ? 5'(DIV_STEPS) : 5'(ROOT_STEPS);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_r <= div_mode;
      res_r  <= '0;
      den_r  <= den;
      if (div_mode) begin
        // The upper quotient bits are known to be zero since num <= den.
        rem_r <= {4'b0000, num[24:1]};
        x_r   <= {num[0], 49'd0};
      end else begin
        rem_r <= '0;
        x_r   <= rad;
      end
    end else if (busy_r) begin
      if (mode_r) begin
        x_r <= {x_r[48:0], 1'b0};
        if (r2 >= den28) begin
          rem_r <= r2 - den28;
          res_r <= {res_r[23:0], 1'b1};
        end else begin
          rem_r <= r2;
          res_r <= {res_r[23:0], 1'b0};
        end
      end else begin
        x_r <= {x_r[47:0], 2'b00};
        if (r4 >= trial) begin
          rem_r <= r4 - trial;
          res_r <= {res_r[23:0], 1'b1};
        end else begin
          rem_r <= r4;
          res_r <= {res_r[23:0], 1'b0};
        end
      end
    end
  end

  assign busy = busy_r;
  assign res  = res_r;

endmodule

`default_nettype wire

/* sv/bsp_ctrl.sv */
// Sequencer of the physics step: walks spheres and pairs and issues one
// datapath command a cycle. Depends on bsp_pkg for command and status types.
`default_nettype none

module bsp_ctrl import bsp_pkg::*; #(
  parameter  int MAX_SPHERES = BSP_MAX_SPHERES,
  localparam int IW = $clog2(MAX_SPHERES),
  localparam int CW = $clog2(MAX_SPHERES + 1)
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        tick_req,
  input  wire logic [3:0]  active_count,
  input  wire dp_status_t  status,
  output logic             busy,
  output dp_cmd_t          cmd,
  output logic [IW-1:0]    addr
);

  typedef enum logic [5:0] {
    S_IDLE, S_RD_I, S_TAKE_I, S_MOVE, S_RD_J, S_TAKE_J, S_DIFF, S_SQ_MUL,
    S_SQ_ACC, S_RR_MUL, S_TEST, S_ROOT_GO, S_ROOT_WAIT, S_TAKE_ROOT,
    S_DIV_GO, S_DIV_WAIT, S_TAKE_Q, S_ACC_CLR, S_DA_MUL, S_DA_ACC, S_A_TEST,
    S_DB_MUL, S_DB_ACC, S_SAVE_DELTA, S_X_MULLO, S_X_ACCLO, S_X_MULHI,
    S_X_ACCHI, S_APPLY, S_WB_J, S_WB_I, S_OUT_RD, S_OUT_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, cnt_r, cnt_nxt, count_w;
  logic [1:0]    k_r, k_nxt;
  dp_cmd_t       cmd_r, cmd_nxt;
  logic [IW-1:0] addr_r, addr_nxt;

  function automatic dp_cmd_t cmd_of(input state_t s);
    dp_cmd_t c;
    c = '{op: OP_NONE, msel: MS_DD, k: 2'd0, last: 1'b0};
    case (s)
      S_RD_I, S_RD_J, S_OUT_RD: c.op = OP_READ;
      S_TAKE_I:     c.op = OP_TAKE_I;
      S_TAKE_J:     c.op = OP_TAKE_J;
      S_MOVE:       c.op = OP_MOVE;
      S_DIFF:       c.op = OP_DIFF;
      S_SQ_MUL:     begin c.op = OP_MUL; c.msel = MS_DD;  end
      S_RR_MUL:     begin c.op = OP_MUL; c.msel = MS_RR;  end
      S_DA_MUL:     begin c.op = OP_MUL; c.msel = MS_UVI; end
      S_DB_MUL:     begin c.op = OP_MUL; c.msel = MS_UVJ; end
      S_X_MULLO:    begin c.op = OP_MUL; c.msel = MS_UDL; end
      S_X_MULHI:    begin c.op = OP_MUL; c.msel = MS_UDH; end
      S_SQ_ACC, S_DA_ACC, S_X_ACCLO: c.op = OP_ACC_ADD;
      S_DB_ACC:     c.op = OP_ACC_SUB;
      S_X_ACCHI:    c.op = OP_ACC_ADD_HI;
      S_ACC_CLR:    c.op = OP_ACC_CLR;
      S_ROOT_GO:    c.op = OP_SQRT_GO;
      S_TAKE_ROOT:  c.op = OP_TAKE_ROOT;
      S_DIV_GO:     c.op = OP_DIV_GO;
      S_TAKE_Q:     c.op = OP_TAKE_Q;
      S_SAVE_DELTA: c.op = OP_SAVE_DELTA;
      S_APPLY:      c.op = OP_APPLY;
      S_WB_I:       c.op = OP_WB_I;
      S_WB_J:       c.op = OP_WB_J;
      S_OUT_EMIT:   c.op = OP_EMIT;
      default:      c.op = OP_NONE;
    endcase
    return c;
  endfunction

  always_comb begin
    count_w = (32'(active_count) > MAX_SPHERES) ? CW'(MAX_SPHERES) : CW'(active_count);
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (start && tick_req && count_w != '0) begin
          cnt_nxt   = count_w;
          i_nxt     = '0;
          state_nxt = S_RD_I;
        end
      end
      S_RD_I:   state_nxt = S_TAKE_I;
      S_TAKE_I: state_nxt = S_MOVE;
      S_MOVE: begin
        if ((i_r + CW'(1)) < cnt_r) begin
          j_nxt     = i_r + CW'(1);
          state_nxt = S_RD_J;
        end else begin
          state_nxt = S_WB_I;
        end
      end
      S_RD_J:   state_nxt = S_TAKE_J;
      S_TAKE_J: state_nxt = S_DIFF;
      S_DIFF: begin
        k_nxt     = 2'd0;
        state_nxt = S_SQ_MUL;
      end
      S_SQ_MUL: state_nxt = S_SQ_ACC;
      S_SQ_ACC: begin
        if (k_r != 2'd2) begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_SQ_MUL;
        end else begin
          state_nxt = S_RR_MUL;
        end
      end
      S_RR_MUL: state_nxt = S_TEST;
      S_TEST:   state_nxt = status.overlap ? S_ROOT_GO : S_WB_J;
      S_ROOT_GO: state_nxt = S_ROOT_WAIT;
      S_ROOT_WAIT: begin
        if (!status.unit_busy) begin
          state_nxt = S_TAKE_ROOT;
        end
      end
      S_TAKE_ROOT: begin
        k_nxt     = 2'd0;
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (!status.unit_busy) begin
          state_nxt = S_TAKE_Q;
        end
      end
      S_TAKE_Q: begin
        if (k_r != 2'd2) begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_DIV_GO;
        end else begin
          k_nxt     = 2'd0;
          state_nxt = S_ACC_CLR;
        end
      end
      S_ACC_CLR: state_nxt = S_DA_MUL;
      S_DA_MUL:  state_nxt = S_DA_ACC;
      S_DA_ACC: begin
        if (k_r != 2'd2) begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_DA_MUL;
        end else begin
          k_nxt     = 2'd0;
          state_nxt = S_A_TEST;
        end
      end
      S_A_TEST: state_nxt = status.a_pos ? S_WB_J : S_DB_MUL;
      S_DB_MUL: state_nxt = S_DB_ACC;
      S_DB_ACC: begin
        if (k_r != 2'd2) begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_DB_MUL;
        end else begin
          k_nxt     = 2'd0;
          state_nxt = S_SAVE_DELTA;
        end
      end
      S_SAVE_DELTA: state_nxt = S_X_MULLO;
      S_X_MULLO:    state_nxt = S_X_ACCLO;
      S_X_ACCLO:    state_nxt = S_X_MULHI;
      S_X_MULHI:    state_nxt = S_X_ACCHI;
      S_X_ACCHI:    state_nxt = S_APPLY;
      S_APPLY: begin
        if (k_r != 2'd2) begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_X_MULLO;
        end else begin
          state_nxt = S_WB_J;
        end
      end
      S_WB_J: begin
        if ((j_r + CW'(1)) < cnt_r) begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_RD_J;
        end else begin
          state_nxt = S_WB_I;
        end
      end
      S_WB_I: begin
        if ((i_r + CW'(1)) < cnt_r) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_RD_I;
        end else begin
          i_nxt     = '0;
          state_nxt = S_OUT_RD;
        end
      end
      S_OUT_RD: state_nxt = S_OUT_EMIT;
      S_OUT_EMIT: begin
        if ((i_r + CW'(1)) < cnt_r) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_OUT_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    cmd_nxt      = cmd_of(state_nxt);
    cmd_nxt.k    = k_nxt;
    cmd_nxt.last = ((i_nxt + CW'(1)) == cnt_nxt);
    if (state_nxt == S_RD_J || state_nxt == S_WB_J) begin
      addr_nxt = j_nxt[IW-1:0];
    end else begin
      addr_nxt = i_nxt[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      cnt_r   <= '0;
      cmd_r   <= '{op: OP_NONE, msel: MS_DD, k: 2'd0, last: 1'b0};
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
      cmd_r   <= cmd_nxt;
      addr_r  <= addr_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign cmd  = cmd_r;
  assign addr = addr_r;

endmodule

`default_nettype wire

/* sv/bsp_dpath.sv */
// Datapath: sphere table memory, working registers of the two spheres of a
// pair, one shared multiplier with accumulator, and the root/divide unit.
// Depends on bsp_pkg and bsp_rootdiv.
`default_nettype none

module bsp_dpath import bsp_pkg::*; #(
  parameter  int MAX_SPHERES = BSP_MAX_SPHERES,
  localparam int IW = $clog2(MAX_SPHERES)
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load_we,
  input  wire in_item_t   in_data,
  input  wire dp_cmd_t    cmd,
  input  wire logic [IW-1:0] addr,
  input  wire q24_t       box_min [3],
  input  wire q24_t       box_max [3],
  output dp_status_t      status,
  output logic            out_valid,
  output out_item_t       out_data
);

  sphere_t mem [MAX_SPHERES];
  sphere_t rd_q_r;
  sphere_t si_r, sj_r;
  sphere_t ld;

  logic signed [24:0] d_r [3];
  logic signed [17:0] u_r [3];
  logic signed [63:0] acc_r;
  logic signed [49:0] prod_r;
  logic [24:0]        n_r;
  logic [44:0]        delta_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic signed [24:0] mul_a, mul_b;
  logic [16:0]        rs;
  logic signed [63:0] prod64, rnd, c64;
  logic signed [16:0] c17;
  logic [23:0]        p_new [3];
  logic [23:0]        v_new [3];
  logic [24:0]        num_abs;
  logic [17:0]        q_mag;
  logic               slot_ok;
  logic [IW-1:0]      load_addr;

  logic        unit_start, unit_busy;
  logic [24:0] unit_res;

  bsp_rootdiv u_rootdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (unit_start),
    .div_mode (cmd.op == OP_DIV_GO),
    .rad      (acc_r[49:0]),
    .num      (num_abs),
    .den      (n_r),
    .busy     (unit_busy),
    .res      (unit_res)
  );

  assign unit_start = (cmd.op == OP_SQRT_GO) || (cmd.op == OP_DIV_GO);

  always_comb begin
    ld.pos    = {in_data.center_z, in_data.center_y, in_data.center_x};
    ld.vel    = {in_data.velocity_z, in_data.velocity_y, in_data.velocity_x};
    ld.radius = in_data.radius;
    slot_ok   = 32'(in_data.sphere_index) < MAX_SPHERES;
    load_addr = IW'(in_data.sphere_index);

    rs = {1'b0, si_r.radius} + {1'b0, sj_r.radius};
    case (cmd.msel)
      MS_DD: begin
        mul_a = d_r[cmd.k];
        mul_b = d_r[cmd.k];
      end
      MS_RR: begin
        mul_a = {8'd0, rs};
        mul_b = {8'd0, rs};
      end
      MS_UVI: begin
        mul_a = 25'(u_r[cmd.k]);
        mul_b = 25'($signed(si_r.vel[cmd.k]));
      end
      MS_UVJ: begin
        mul_a = 25'(u_r[cmd.k]);
        mul_b = 25'($signed(sj_r.vel[cmd.k]));
      end
      MS_UDL: begin
        mul_a = 25'(u_r[cmd.k]);
        mul_b = {1'b0, delta_r[23:0]};
      end
      MS_UDH: begin
        mul_a = 25'(u_r[cmd.k]);
        mul_b = 25'($signed(delta_r[44:24]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    prod64 = 64'(prod_r);
    rnd    = acc_r + 64'sh0000_8000_0000_0000;
    c64    = rnd >>> 48;
    c17    = c64[16:0];

    for (int k = 0; k < 3; k++) begin
      p_new[k] = sat24(26'($signed(si_r.pos[k])) + 26'($signed(si_r.vel[k])));
      v_new[k] = si_r.vel[k];
      if ($signed(p_new[k]) < box_min[k]) begin
        v_new[k] = abs_sat24(si_r.vel[k]);
      end
      if ($signed(p_new[k]) > box_max[k]) begin
        v_new[k] = ~abs_sat24(si_r.vel[k]) + 24'd1;
      end
    end

    num_abs = d_r[cmd.k][24] ? (~d_r[cmd.k] + 25'd1) : d_r[cmd.k];
    q_mag   = {1'b0, unit_res[16:0]};
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (load_we && slot_ok) begin
      mem[load_addr] <= ld;
    end else if (cmd.op == OP_WB_I) begin
      mem[addr] <= si_r;
    end else if (cmd.op == OP_WB_J) begin
      mem[addr] <= sj_r;
    end
    if (cmd.op == OP_READ) begin
      rd_q_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_TAKE_I: si_r <= rd_q_r;
      OP_TAKE_J: sj_r <= rd_q_r;
      OP_MOVE: begin
        for (int k = 0; k < 3; k++) begin
          si_r.pos[k] <= p_new[k];
          si_r.vel[k] <= v_new[k];
        end
      end
      OP_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          d_r[k] <= 25'($signed(si_r.pos[k])) - 25'($signed(sj_r.pos[k]));
        end
        acc_r <= '0;
      end
      OP_MUL:        prod_r <= mul_a * mul_b;
      OP_ACC_ADD:    acc_r  <= acc_r + prod64;
      OP_ACC_SUB:    acc_r  <= acc_r - prod64;
      OP_ACC_ADD_HI: acc_r  <= acc_r + (prod64 <<< 24);
      OP_ACC_CLR:    acc_r  <= '0;
      OP_TAKE_ROOT:  n_r    <= unit_res;
      OP_TAKE_Q: begin
        u_r[cmd.k] <= d_r[cmd.k][24] ? (~q_mag + 18'd1) : q_mag;
      end
      OP_SAVE_DELTA: begin
        delta_r <= acc_r[44:0];
        acc_r   <= '0;
      end
      OP_APPLY: begin
        si_r.vel[cmd.k] <= sat24(26'($signed(si_r.vel[cmd.k])) - 26'(c17));
        sj_r.vel[cmd.k] <= sat24(26'($signed(sj_r.vel[cmd.k])) + 26'(c17));
        acc_r <= '0;
      end
      OP_EMIT: begin
        out_r.result_index <= 3'(addr);
        out_r.moved_x      <= rd_q_r.pos[0];
        out_r.moved_y      <= rd_q_r.pos[1];
        out_r.moved_z      <= rd_q_r.pos[2];
        out_r.speed_x      <= rd_q_r.vel[0];
        out_r.speed_y      <= rd_q_r.vel[1];
        out_r.speed_z      <= rd_q_r.vel[2];
        out_r.last_sphere  <= cmd.last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == OP_EMIT);
    end
  end

  assign status.overlap   = (acc_r[49:0] < prod_r[49:0]) && (acc_r[49:0] != '0);
  assign status.a_pos     = (acc_r > 64'sd0);
  assign status.unit_busy = unit_busy;
  assign out_valid        = out_valid_r;
  assign out_data         = out_r;

endmodule

`default_nettype wire

/* sv/bsp_checker.sv */
// Port-level checks of the bouncing-sphere physics step, bound to the top.
// Depends on bsp_pkg for the beat types.
`default_nettype none

module bsp_checker import bsp_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire in_item_t  in_data,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire out_item_t out_data
);

  // Reset leaves the block idle with no result beat.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  // A load completes at once and never produces a result beat.
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_data.mode |=> !busy && !out_valid)
    else $error("load item made the block busy or produced a beat");

  // Result beats are spaced by the read cycle of the next sphere.
  a_beat_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result beats in consecutive cycles");

  // The final beat of a tick coincides with the block going idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_sphere |-> !busy)
    else $error("busy still high on the final beat");

  // Any earlier beat of a tick is shown while the block is still busy.
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_sphere |-> busy)
    else $error("non-final beat shown while idle");

endmodule

bind bouncing_sphere_physics_step bsp_checker u_bsp_checker (.*);

`default_nettype wire
